// ----- sv/exl_pkg.sv -----
// shared types, character codes and default widths of the expression lexer
package exl_pkg;

   localparam int EXL_NUMBER_BITS = 32;
   localparam int EXL_COUNT_BITS  = 16;

   typedef enum logic [4:0] {
      KIND_NUMBER = 5'd0,
      KIND_ASSIGN = 5'd1,
      KIND_EQ     = 5'd2,
      KIND_LT     = 5'd3,
      KIND_LE     = 5'd4,
      KIND_GT     = 5'd5,
      KIND_GE     = 5'd6,
      KIND_NOT    = 5'd7,
      KIND_NE     = 5'd8,
      KIND_PLUS   = 5'd9,
      KIND_MINUS  = 5'd10,
      KIND_STAR   = 5'd11,
      KIND_SLASH  = 5'd12,
      KIND_LPAREN = 5'd13,
      KIND_RPAREN = 5'd14,
      KIND_CARET  = 5'd15,
      KIND_SEMI   = 5'd16,
      KIND_ERROR  = 5'd17
   } kind_type;

   localparam logic [7:0] CHAR_TAB     = 8'd9;
   localparam logic [7:0] CHAR_NEWLINE = 8'd10;
   localparam logic [7:0] CHAR_VTAB    = 8'd11;
   localparam logic [7:0] CHAR_FEED    = 8'd12;
   localparam logic [7:0] CHAR_RETURN  = 8'd13;
   localparam logic [7:0] CHAR_SPACE   = 8'd32;
   localparam logic [7:0] CHAR_BANG    = 8'h21;
   localparam logic [7:0] CHAR_LPAREN  = 8'h28;
   localparam logic [7:0] CHAR_RPAREN  = 8'h29;
   localparam logic [7:0] CHAR_STAR    = 8'h2A;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_MINUS   = 8'h2D;
   localparam logic [7:0] CHAR_SLASH   = 8'h2F;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_SEMI    = 8'h3B;
   localparam logic [7:0] CHAR_LESS    = 8'h3C;
   localparam logic [7:0] CHAR_EQUAL   = 8'h3D;
   localparam logic [7:0] CHAR_GREATER = 8'h3E;
   localparam logic [7:0] CHAR_CARET   = 8'h5E;

endpackage

// ----- sv/exl_req_if.sv -----
// character channel of the expression lexer
interface exl_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_in;

   modport source (output valid, output char_in, input ready);
   modport sink (input valid, input char_in, output ready);
endinterface

// ----- sv/exl_rsp_if.sv -----
// lexeme result channel of the expression lexer
interface exl_rsp_if #(
   parameter int NUMBER_BITS = 32,
   parameter int COUNT_BITS  = 16
);
   logic                   valid;
   logic                   ready;
   logic [4:0]             lexeme_kind;
   logic [COUNT_BITS-1:0]  lexeme_index;
   logic [COUNT_BITS-1:0]  statement_number;
   logic [NUMBER_BITS-1:0] number_value;
   logic                   number_overflow;
   logic [7:0]             bad_char;
   logic                   statement_first;
   logic                   last_of_run;

   modport source (
      output valid, output lexeme_kind, output lexeme_index, output statement_number,
      output number_value, output number_overflow, output bad_char,
      output statement_first, output last_of_run, input ready
   );
   modport sink (
      input valid, input lexeme_kind, input lexeme_index, input statement_number,
      input number_value, input number_overflow, input bad_char,
      input statement_first, input last_of_run, output ready
   );
endinterface

// ----- sv/expression_lexer.sv -----
// top level of the expression lexer: input register, lexer and result queue
//
//  channel  | dir | handshake             | payload
//  req_ch   | in  | valid/ready           | char_in
//  rsp_ch   | out | valid/ready           | kind, index, statement, value, flags
//
//  one character item enters per cycle while the result queue has room; results pass the input register and the queue
//  a character yielding two lexemes writes both into the queue at once; the single result port shows them in turn
//  the four-entry result queue takes the next character while results wait, as long as two entries are free
//  synchronous reset, no clearing pass; state returns to statement one
//  either side may stall at any time; nothing is lost or repeated
module expression_lexer import exl_pkg::*; #(
   parameter int NUMBER_BITS = EXL_NUMBER_BITS,
   parameter int COUNT_BITS  = EXL_COUNT_BITS
) (
   input logic clock,
   input logic reset,
   exl_req_if.sink   req_ch,
   exl_rsp_if.source rsp_ch
);

   localparam int DEPTH    = 4;
   localparam int PTR_BITS = $clog2(DEPTH);
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   typedef struct packed {
      kind_type               kind;
      logic [COUNT_BITS-1:0]  index;
      logic [COUNT_BITS-1:0]  statement;
      logic [NUMBER_BITS-1:0] value;
      logic                   overflow;
      logic [7:0]             bad;
      logic                   first;
      logic                   last;
   } entry_type;

   logic                   in_valid_ff, in_valid_in;
   logic [7:0]             char_ff;
   logic                   advance, pop;

   logic [1:0]             res_count;
   kind_type               kind0, kind1;
   logic [NUMBER_BITS-1:0] value0;
   logic                   overflow0, first0;
   logic [7:0]             bad0, bad1;
   logic [COUNT_BITS-1:0]  index0, index1, statement;

   entry_type              queue_ff [DEPTH];
   entry_type              entry0, entry1;
   logic [PTR_BITS-1:0]    wr_ff, rd_ff;
   logic [CNT_BITS-1:0]    count_ff;

   assign advance       = in_valid_ff && (count_ff <= CNT_BITS'(DEPTH - 2));
   assign req_ch.ready  = !in_valid_ff || advance;
   assign in_valid_in   = req_ch.valid || (in_valid_ff && !advance);
   assign pop           = rsp_ch.valid && rsp_ch.ready;

   exl_lexer #(
      .NUMBER_BITS (NUMBER_BITS),
      .COUNT_BITS  (COUNT_BITS)
   ) u_lexer (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .char_in   (char_ff),
      .res_count (res_count),
      .kind0     (kind0),
      .value0    (value0),
      .overflow0 (overflow0),
      .bad0      (bad0),
      .index0    (index0),
      .first0    (first0),
      .kind1     (kind1),
      .bad1      (bad1),
      .index1    (index1),
      .statement (statement)
   );

   always_comb begin
      entry0.kind      = kind0;
      entry0.index     = index0;
      entry0.statement = statement;
      entry0.value     = value0;
      entry0.overflow  = overflow0;
      entry0.bad       = bad0;
      entry0.first     = first0;
      entry0.last      = (res_count == 2'd1);
      entry1.kind      = kind1;
      entry1.index     = index1;
      entry1.statement = statement;
      entry1.value     = '0;
      entry1.overflow  = 1'b0;
      entry1.bad       = bad1;
      entry1.first     = 1'b0;
      entry1.last      = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (req_ch.ready) begin
         char_ff <= req_ch.char_in;
      end
      if (res_count != 2'd0) begin
         queue_ff[wr_ff] <= entry0;
      end
      if (res_count == 2'd2) begin
         queue_ff[wr_ff + 1'b1] <= entry1;
      end
      if (reset) begin
         in_valid_ff <= 1'b0;
         wr_ff       <= '0;
         rd_ff       <= '0;
         count_ff    <= '0;
      end else begin
         if (req_ch.ready) begin
            in_valid_ff <= in_valid_in;
         end
         wr_ff    <= wr_ff + PTR_BITS'(res_count);
         rd_ff    <= rd_ff + PTR_BITS'(pop);
         count_ff <= count_ff + CNT_BITS'(res_count) - CNT_BITS'(pop);
      end
   end

   assign rsp_ch.valid            = (count_ff != '0);
   assign rsp_ch.lexeme_kind      = queue_ff[rd_ff].kind;
   assign rsp_ch.lexeme_index     = queue_ff[rd_ff].index;
   assign rsp_ch.statement_number = queue_ff[rd_ff].statement;
   assign rsp_ch.number_value     = queue_ff[rd_ff].value;
   assign rsp_ch.number_overflow  = queue_ff[rd_ff].overflow;
   assign rsp_ch.bad_char         = queue_ff[rd_ff].bad;
   assign rsp_ch.statement_first  = queue_ff[rd_ff].first;
   assign rsp_ch.last_of_run      = queue_ff[rd_ff].last;

endmodule

// ----- sv/exl_lexer.sv -----
// lexer state and per-character logic, up to two results per character
module exl_lexer import exl_pkg::*; #(
   parameter int NUMBER_BITS = EXL_NUMBER_BITS,
   parameter int COUNT_BITS  = EXL_COUNT_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic [7:0]             char_in,
   output logic [1:0]             res_count,
   output kind_type               kind0,
   output logic [NUMBER_BITS-1:0] value0,
   output logic                   overflow0,
   output logic [7:0]             bad0,
   output logic [COUNT_BITS-1:0]  index0,
   output logic                   first0,
   output kind_type               kind1,
   output logic [7:0]             bad1,
   output logic [COUNT_BITS-1:0]  index1,
   output logic [COUNT_BITS-1:0]  statement
);

   typedef enum logic [2:0] {
      HOLD_NONE = 3'd0,
      HOLD_EQ   = 3'd1,
      HOLD_LT   = 3'd2,
      HOLD_GT   = 3'd3,
      HOLD_BANG = 3'd4,
      HOLD_NUM  = 3'd5
   } hold_type;

   localparam int WIDE_BITS = NUMBER_BITS + 4;
   localparam logic [COUNT_BITS-1:0]  COUNT_MAX  = '1;
   localparam logic [NUMBER_BITS-1:0] NUMBER_MAX = '1;

   function automatic kind_type flush_kind(input hold_type h);
      kind_type k;
      unique case (h)
         HOLD_EQ:   k = KIND_ASSIGN;
         HOLD_LT:   k = KIND_LT;
         HOLD_GT:   k = KIND_GT;
         HOLD_BANG: k = KIND_NOT;
         default:   k = KIND_NUMBER;
      endcase
      return k;
   endfunction

   function automatic kind_type pair_kind(input hold_type h);
      kind_type k;
      unique case (h)
         HOLD_EQ:   k = KIND_EQ;
         HOLD_LT:   k = KIND_LE;
         HOLD_GT:   k = KIND_GE;
         default:   k = KIND_NE;
      endcase
      return k;
   endfunction

   function automatic hold_type hold_of(input logic [7:0] c);
      hold_type h;
      unique case (c)
         CHAR_EQUAL:   h = HOLD_EQ;
         CHAR_LESS:    h = HOLD_LT;
         CHAR_GREATER: h = HOLD_GT;
         CHAR_BANG:    h = HOLD_BANG;
         default:      h = HOLD_NONE;
      endcase
      return h;
   endfunction

   function automatic kind_type single_kind(input logic [7:0] c);
      kind_type k;
      unique case (c)
         CHAR_PLUS:   k = KIND_PLUS;
         CHAR_MINUS:  k = KIND_MINUS;
         CHAR_STAR:   k = KIND_STAR;
         CHAR_SLASH:  k = KIND_SLASH;
         CHAR_LPAREN: k = KIND_LPAREN;
         CHAR_RPAREN: k = KIND_RPAREN;
         CHAR_CARET:  k = KIND_CARET;
         CHAR_SEMI:   k = KIND_SEMI;
         default:     k = KIND_ERROR;
      endcase
      return k;
   endfunction

   hold_type               hold_ff, hold_in;
   logic [NUMBER_BITS-1:0] accum_ff, accum_in;
   logic                   sat_ff, sat_in;
   logic [COUNT_BITS-1:0]  count_ff, count_in;
   logic [COUNT_BITS-1:0]  stmt_ff, stmt_in;
   logic                   start_ff, start_in;
   logic                   line_ff, line_in;
   logic                   header_ff, header_in;

   logic                   is_space, is_digit, is_newline, do_flush;
   logic                   e0_valid, e1_valid;
   logic [3:0]             digit;
   logic [WIDE_BITS-1:0]   wide_accum, wide_next;
   logic [COUNT_BITS-1:0]  count_mid;

   assign is_newline = (char_in == CHAR_NEWLINE);
   assign is_space   = (char_in == CHAR_TAB) || (char_in == CHAR_VTAB) ||
                       (char_in == CHAR_FEED) || (char_in == CHAR_RETURN) ||
                       (char_in == CHAR_SPACE);
   assign is_digit   = (char_in >= CHAR_ZERO) && (char_in <= CHAR_NINE);
   assign digit      = char_in[3:0];
   assign wide_accum = {4'b0000, accum_ff};
   assign wide_next  = (wide_accum << 3) + (wide_accum << 1) + WIDE_BITS'(digit);

   always_comb begin
      hold_in   = hold_ff;
      accum_in  = accum_ff;
      sat_in    = sat_ff;
      count_in  = count_ff;
      stmt_in   = stmt_ff;
      start_in  = start_ff;
      line_in   = line_ff;
      header_in = header_ff;
      do_flush  = 1'b0;
      e0_valid  = 1'b0;
      e1_valid  = 1'b0;
      kind0     = KIND_NUMBER;
      value0    = '0;
      overflow0 = 1'b0;
      kind1     = KIND_NUMBER;
      bad1      = 8'd0;

      if (step && !is_space) begin
         if (is_newline) begin
            do_flush = 1'b1;
            hold_in  = HOLD_NONE;
            accum_in = '0;
            sat_in   = 1'b0;
         end else begin
            line_in  = 1'b1;
            start_in = (char_in == CHAR_SEMI);
            priority if (char_in == CHAR_EQUAL && hold_ff != HOLD_NONE &&
                         hold_ff != HOLD_NUM) begin
               e0_valid = 1'b1;
               kind0    = pair_kind(hold_ff);
               hold_in  = HOLD_NONE;
            end else if (is_digit) begin
               if (hold_ff != HOLD_NUM) begin
                  do_flush = 1'b1;
                  hold_in  = HOLD_NUM;
                  accum_in = NUMBER_BITS'(digit);
                  sat_in   = 1'b0;
               end else if (!sat_ff) begin
                  if (wide_next > {4'b0000, NUMBER_MAX}) begin
                     accum_in = NUMBER_MAX;
                     sat_in   = 1'b1;
                  end else begin
                     accum_in = wide_next[NUMBER_BITS-1:0];
                  end
               end
            end else begin
               do_flush = 1'b1;
               hold_in  = hold_of(char_in);
               accum_in = '0;
               sat_in   = 1'b0;
               if (hold_of(char_in) == HOLD_NONE) begin
                  e1_valid = 1'b1;
                  kind1    = single_kind(char_in);
                  bad1     = (single_kind(char_in) == KIND_ERROR) ? char_in : 8'd0;
               end
            end
         end
      end

      if (do_flush && hold_ff != HOLD_NONE) begin
         e0_valid  = 1'b1;
         kind0     = flush_kind(hold_ff);
         value0    = (hold_ff == HOLD_NUM) ? accum_ff : '0;
         overflow0 = (hold_ff == HOLD_NUM) && sat_ff;
      end

      count_mid = (e0_valid && count_ff != COUNT_MAX) ? count_ff + 1'b1 : count_ff;
      if (e1_valid && kind1 != KIND_ERROR && count_mid != COUNT_MAX) begin
         count_in = count_mid + 1'b1;
      end else begin
         count_in = count_mid;
      end
      header_in = header_ff && !e0_valid && !e1_valid;

      if (step && is_newline) begin
         if (line_ff && start_ff) begin
            if (stmt_ff != COUNT_MAX) begin
               stmt_in = stmt_ff + 1'b1;
            end
            count_in = '0;
         end
         line_in   = 1'b0;
         header_in = start_ff;
      end

      // the first result out is the flushed or two-character lexeme, if any
      res_count = {1'b0, e0_valid} + {1'b0, e1_valid};
      if (!e0_valid) begin
         kind0     = kind1;
      end
      bad0      = e0_valid ? 8'd0 : bad1;
      index0    = count_ff;
      index1    = count_mid;
      first0    = header_ff;
      statement = stmt_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff   <= HOLD_NONE;
         accum_ff  <= '0;
         sat_ff    <= 1'b0;
         count_ff  <= '0;
         stmt_ff   <= COUNT_BITS'(1);
         start_ff  <= 1'b1;
         line_ff   <= 1'b0;
         header_ff <= 1'b1;
      end else begin
         hold_ff   <= hold_in;
         accum_ff  <= accum_in;
         sat_ff    <= sat_in;
         count_ff  <= count_in;
         stmt_ff   <= stmt_in;
         start_ff  <= start_in;
         line_ff   <= line_in;
         header_ff <= header_in;
      end
   end

endmodule

// ----- sv/exl_checker.sv -----
// port-level checks of the expression lexer and their binding
module exl_checker import exl_pkg::*; #(
   parameter int NUMBER_BITS = EXL_NUMBER_BITS,
   parameter int COUNT_BITS  = EXL_COUNT_BITS
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [4:0]             rsp_kind,
   input logic [COUNT_BITS-1:0]  rsp_index,
   input logic [NUMBER_BITS-1:0] rsp_value,
   input logic                   rsp_overflow,
   input logic [7:0]             rsp_bad
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_index))
      else $error("result item dropped or changed while stalled");

   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result item shown right after reset");

   a_value_only_number: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_NUMBER |-> rsp_value == '0 && !rsp_overflow)
      else $error("number value on a non-number lexeme");

   a_bad_only_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_ERROR |-> rsp_bad == 8'd0)
      else $error("bad character on a valid lexeme");

endmodule

bind expression_lexer exl_checker #(
   .NUMBER_BITS (NUMBER_BITS),
   .COUNT_BITS  (COUNT_BITS)
) u_exl_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .rsp_kind     (rsp_ch.lexeme_kind),
   .rsp_index    (rsp_ch.lexeme_index),
   .rsp_value    (rsp_ch.number_value),
   .rsp_overflow (rsp_ch.number_overflow),
   .rsp_bad      (rsp_ch.bad_char)
);

// ----- verif/tb_top.sv -----
// testbench for the expression lexer: lexeme prediction, result checking and stimulus
module tb_top import exl_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint unsigned NUM_MAX = 64'h0000_0000_FFFF_FFFF;
   localparam logic [15:0] CNT_MAX = 16'hFFFF;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int HOLD_CYCLES = 80;
   localparam int DRAIN_CYCLES = 8;
   localparam int RANDOM_ITEMS = 1300;

   typedef enum logic [2:0] {
      HELD_NONE, HELD_ASSIGN, HELD_LESS, HELD_GREATER, HELD_BANG, HELD_NUMBER
   } held_type;

   typedef struct {
      kind_type    kind;
      logic [15:0] index;
      logic [15:0] statement;
      logic [31:0] value;
      logic        overflow;
      logic [7:0]  bad_char;
      logic        first;
      logic        last;
   } lexeme_type;

   logic clock = 1'b0;
   logic reset;

   exl_req_if req_ch ();
   exl_rsp_if #(.NUMBER_BITS(EXL_NUMBER_BITS), .COUNT_BITS(EXL_COUNT_BITS)) rsp_ch ();

   expression_lexer dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #10 clock = ~clock;

   lexeme_type  lexemes_due[$];
   lexeme_type  staged;
   bit          staged_valid = 1'b0;
   held_type    held = HELD_NONE;
   logic [31:0] accum = '0;
   bit          accum_sat = 1'b0;
   logic [15:0] lex_count = '0;
   logic [15:0] stmt_count = 16'd1;
   bit          stmt_open = 1'b1;
   bit          line_used = 1'b0;
   bit          header_pending = 1'b1;
   int          lexed_items = 0;
   int          failures = 0;
   int          idle_cycles = 0;
   bit          steady = 1'b0;
   bit          hold_due = 1'b0;
   int          hold_count;

   string op_texts[15] = '{"=", "==", "<", "<=", ">", ">=", "!", "!=",
                           "+", "-", "*", "/", "(", ")", "^"};
   logic [7:0] blank_chars[5] = '{CHAR_TAB, CHAR_VTAB, CHAR_FEED, CHAR_RETURN, CHAR_SPACE};

   function void emit_lexeme(kind_type kind, logic [31:0] value, logic overflow,
                             logic [7:0] bad);
      lexeme_type e;
      e.kind = kind;
      e.index = lex_count;
      e.statement = stmt_count;
      e.value = value;
      e.overflow = overflow;
      e.bad_char = bad;
      e.first = header_pending;
      e.last = 1'b0;
      header_pending = 1'b0;
      if (kind != KIND_ERROR && lex_count != CNT_MAX) lex_count++;
      if (staged_valid) lexemes_due.push_back(staged);
      staged = e;
      staged_valid = 1'b1;
   endfunction

   function void flush_held();
      case (held)
         HELD_NUMBER:  emit_lexeme(KIND_NUMBER, accum, accum_sat, 8'd0);
         HELD_ASSIGN:  emit_lexeme(KIND_ASSIGN, '0, 1'b0, 8'd0);
         HELD_LESS:    emit_lexeme(KIND_LT, '0, 1'b0, 8'd0);
         HELD_GREATER: emit_lexeme(KIND_GT, '0, 1'b0, 8'd0);
         HELD_BANG:    emit_lexeme(KIND_NOT, '0, 1'b0, 8'd0);
         default: ;
      endcase
      held = HELD_NONE;
      accum = '0;
      accum_sat = 1'b0;
   endfunction

   function void lex_char(logic [7:0] c);
      longint unsigned digit;
      if (c == CHAR_NEWLINE) begin
         flush_held();
         if (line_used && stmt_open) begin
            if (stmt_count != CNT_MAX) stmt_count++;
            lex_count = '0;
         end
         line_used = 1'b0;
         header_pending = stmt_open;
      end else if (!(c inside {CHAR_TAB, CHAR_VTAB, CHAR_FEED, CHAR_RETURN, CHAR_SPACE})) begin
         lexed_items++;
         line_used = 1'b1;
         stmt_open = (c == CHAR_SEMI);
         if (c == CHAR_EQUAL && held inside {HELD_ASSIGN, HELD_LESS, HELD_GREATER, HELD_BANG})
         begin
            case (held)
               HELD_ASSIGN:  emit_lexeme(KIND_EQ, '0, 1'b0, 8'd0);
               HELD_LESS:    emit_lexeme(KIND_LE, '0, 1'b0, 8'd0);
               HELD_GREATER: emit_lexeme(KIND_GE, '0, 1'b0, 8'd0);
               default:      emit_lexeme(KIND_NE, '0, 1'b0, 8'd0);
            endcase
            held = HELD_NONE;
         end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            digit = c - CHAR_ZERO;
            if (held != HELD_NUMBER) begin
               flush_held();
               held = HELD_NUMBER;
               accum = digit[31:0];
               accum_sat = 1'b0;
            end else if (!accum_sat) begin
               if (longint'(accum) > (NUM_MAX - digit) / 10) begin
                  accum = NUM_MAX[31:0];
                  accum_sat = 1'b1;
               end else begin
                  accum = 32'(longint'(accum) * 10 + digit);
               end
            end
         end else begin
            flush_held();
            case (c)
               CHAR_EQUAL:   held = HELD_ASSIGN;
               CHAR_LESS:    held = HELD_LESS;
               CHAR_GREATER: held = HELD_GREATER;
               CHAR_BANG:    held = HELD_BANG;
               CHAR_PLUS:    emit_lexeme(KIND_PLUS, '0, 1'b0, 8'd0);
               CHAR_MINUS:   emit_lexeme(KIND_MINUS, '0, 1'b0, 8'd0);
               CHAR_STAR:    emit_lexeme(KIND_STAR, '0, 1'b0, 8'd0);
               CHAR_SLASH:   emit_lexeme(KIND_SLASH, '0, 1'b0, 8'd0);
               CHAR_LPAREN:  emit_lexeme(KIND_LPAREN, '0, 1'b0, 8'd0);
               CHAR_RPAREN:  emit_lexeme(KIND_RPAREN, '0, 1'b0, 8'd0);
               CHAR_CARET:   emit_lexeme(KIND_CARET, '0, 1'b0, 8'd0);
               CHAR_SEMI:    emit_lexeme(KIND_SEMI, '0, 1'b0, 8'd0);
               default:      emit_lexeme(KIND_ERROR, '0, 1'b0, c);
            endcase
         end
      end
      if (staged_valid) begin
         staged.last = 1'b1;
         lexemes_due.push_back(staged);
         staged_valid = 1'b0;
      end
   endfunction

   function int pick_gap();
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endfunction

   task send_char(input logic [7:0] c);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         req_ch.char_in <= 8'($urandom);
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.char_in <= c;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      lex_char(c);
   endtask

   task send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i]);
   endtask

   task wait_drained();
      req_ch.valid <= 1'b0;
      while (lexemes_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task test_operators();
      send_text("==<=>=!==<>!+-*/()^;\n");
      wait_drained();
   endtask

   task test_special_chars();
      send_char(8'h00);
      send_text("a");
      send_char(8'h80);
      send_char(8'hFF);
      send_text(" 1\t2\r3<\n\n7\n");
      wait_drained();
   endtask

   task test_number_limits();
      send_text("4294967295+4294967296;\n");
      wait_drained();
   endtask

   task test_backpressure();
      hold_due = 1'b1;
      repeat (12) send_text("12+3;\n");
      wait_drained();
   endtask

   task send_token();
      int r;
      int digits;
      r = $urandom_range(0, 99);
      if (r < 40) begin
         digits = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 4);
         repeat (digits) begin
            send_char(CHAR_ZERO + 8'($urandom_range(0, 9)));
            if ($urandom_range(0, 19) == 0) send_char(CHAR_SPACE);
         end
      end else if (r < 85) begin
         send_text(op_texts[$urandom_range(0, 14)]);
      end else if (r < 93) begin
         send_char(blank_chars[$urandom_range(0, 4)]);
      end else begin
         send_char(8'($urandom));
      end
   endtask

   task test_random_statements();
      int start;
      int r;
      start = lexed_items;
      while (lexed_items - start < RANDOM_ITEMS) begin
         steady = (lexed_items - start >= 600 && lexed_items - start < 800);
         r = $urandom_range(0, 99);
         if (r < 5) begin
            send_text($urandom_range(0, 1) ? "\n" : " \t\n");
         end else if (r < 15) begin
            repeat ($urandom_range(1, 4)) send_char(8'($urandom));
         end else begin
            repeat ($urandom_range(1, 8)) send_token();
            if ($urandom_range(0, 9) != 0) send_char(CHAR_SEMI);
            if ($urandom_range(0, 9) < 6) send_char(CHAR_NEWLINE);
         end
      end
      steady = 1'b0;
      send_char(CHAR_NEWLINE);
      wait_drained();
   endtask

   initial begin
      int stall;
      stall = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_due) begin
            rsp_ch.ready <= 1'b0;
            hold_count = 0;
            while (hold_count < HOLD_CYCLES) begin
               @(posedge clock);
               hold_count++;
            end
            hold_due = 1'b0;
         end else if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            stall--;
         end else begin
            rsp_ch.ready <= 1'b1;
            stall = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      lexeme_type e;
      if (reset === 1'b0 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (lexemes_due.size() == 0) begin
            $error("result with no lexeme due: kind %0d", rsp_ch.lexeme_kind);
            failures++;
         end else begin
            e = lexemes_due.pop_front();
            check_field("lexeme_kind", e.kind, rsp_ch.lexeme_kind);
            check_field("lexeme_index", e.index, rsp_ch.lexeme_index);
            check_field("statement_number", e.statement, rsp_ch.statement_number);
            check_field("number_value", e.value, rsp_ch.number_value);
            check_field("number_overflow", e.overflow, rsp_ch.number_overflow);
            check_field("bad_char", e.bad_char, rsp_ch.bad_char);
            check_field("statement_first", e.first, rsp_ch.statement_first);
            check_field("last_of_run", e.last, rsp_ch.last_of_run);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
          (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.char_in = 8'd0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_operators();
      test_special_chars();
      test_number_limits();
      test_backpressure();
      test_random_statements();
      if (failures == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
sv/exl_pkg.sv
sv/exl_req_if.sv
sv/exl_rsp_if.sv
sv/exl_lexer.sv
sv/expression_lexer.sv
sv/exl_checker.sv
verif/tb_top.sv
